// ===== rtl/bnis_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bnis_pkg
// shared constants for the image scaler: parameter defaults, register
// indexes, register reset values, command codes and interpolation mode codes
// ----------------------------------------------------------------------------
package bnis_pkg;

    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_FRAC_BITS    = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_X_SCALE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_SCALE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERP_MODE = 3'd5;

    localparam logic [8:0]  RST_SRC_WIDTH   = 9'd256;
    localparam logic [8:0]  RST_SRC_HEIGHT  = 9'd256;
    localparam logic [2:0]  RST_CHANNELS    = 3'd1;
    localparam logic [15:0] RST_X_SCALE     = 16'd256;
    localparam logic [15:0] RST_Y_SCALE     = 16'd256;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/bilinear_nearest_image_scaler_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_nearest_image_scaler_core
// frame store plus a sequenced scaler that answers one output sample per
// request, in nearest or bilinear mode
// ----------------------------------------------------------------------------
// A load (cmd 0) writes one sample into the frame store in the cycle it is
// accepted and leaves busy low, so loads can follow every cycle. A request
// (cmd 1) holds busy high while one shared restoring divider finds the source
// column and then the source row, one quotient bit per cycle, and then up to
// four frame-store reads go through the single read port, blended by one
// shared multiplier. A request outside the output image answers from the size
// check without running the divider. The result shows for one cycle with
// done high and cannot be held off, so the receiver must take it then.
module bilinear_nearest_image_scaler_core #(
    parameter int MAX_WIDTH    = bnis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = bnis_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = bnis_pkg::DEF_MAX_CHANNELS,
    parameter int FRAC_BITS    = bnis_pkg::DEF_FRAC_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [bnis_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bnis_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             cmd,
    input  wire logic [15:0]                      col,
    input  wire logic [15:0]                      row,
    input  wire logic [1:0]                       channel,
    input  wire logic [7:0]                       pixel_value,
    output logic                                  done,
    output logic [7:0]                            out_pixel,
    output logic                                  coord_error,
    output logic [15:0]                           out_cols,
    output logic [15:0]                           out_rows
);

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DWW   = $clog2(MAX_WIDTH + 1);
    localparam int DHW   = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = 16 + 2 * FRAC_BITS;
    localparam int IW    = QW - FRAC_BITS;
    localparam int CNTW  = $clog2(QW + 1);
    localparam int WW    = FRAC_BITS + 1;
    localparam int HW    = 8 + FRAC_BITS;
    localparam int VW    = 8 + 2 * FRAC_BITS;
    localparam int MPW   = HW + WW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SIZE = 4'd1;
    localparam logic [3:0] S_DIVX = 4'd2;
    localparam logic [3:0] S_DIVY = 4'd3;
    localparam logic [3:0] S_IDX  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_MV   = 4'd7;

    localparam logic [WW-1:0] ONE_W = WW'(1) << FRAC_BITS;
    localparam logic [QW:0]   HALF  = (QW + 1)'(1) << (FRAC_BITS - 1);

    // configuration registers
    logic [8:0]  src_width_reg;
    logic [8:0]  src_height_reg;
    logic [2:0]  channels_reg;
    logic [15:0] x_scale_reg;
    logic [15:0] y_scale_reg;
    logic        interp_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= bnis_pkg::RST_SRC_WIDTH;
            src_height_reg  <= bnis_pkg::RST_SRC_HEIGHT;
            channels_reg    <= bnis_pkg::RST_CHANNELS;
            x_scale_reg     <= bnis_pkg::RST_X_SCALE;
            y_scale_reg     <= bnis_pkg::RST_Y_SCALE;
            interp_mode_reg <= bnis_pkg::MODE_BILINEAR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bnis_pkg::REG_SRC_WIDTH:   src_width_reg   <= cfg_data[8:0];
                bnis_pkg::REG_SRC_HEIGHT:  src_height_reg  <= cfg_data[8:0];
                bnis_pkg::REG_CHANNELS:    channels_reg    <= cfg_data[2:0];
                bnis_pkg::REG_X_SCALE:     x_scale_reg     <= cfg_data;
                bnis_pkg::REG_Y_SCALE:     y_scale_reg     <= cfg_data;
                bnis_pkg::REG_INTERP_MODE: interp_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective dimensions and scales
    logic [DWW-1:0] eff_w;
    logic [DHW-1:0] eff_h;
    logic [2:0]     eff_c;
    logic [15:0]    eff_xs;
    logic [15:0]    eff_ys;

    always_comb
    begin
        if (src_width_reg == 9'd0)
            eff_w = DWW'(1);
        else if (32'(src_width_reg) > MAX_WIDTH)
            eff_w = DWW'(MAX_WIDTH);
        else
            eff_w = DWW'(src_width_reg);
        if (src_height_reg == 9'd0)
            eff_h = DHW'(1);
        else if (32'(src_height_reg) > MAX_HEIGHT)
            eff_h = DHW'(MAX_HEIGHT);
        else
            eff_h = DHW'(src_height_reg);
        if (channels_reg == 3'd0)
            eff_c = 3'd1;
        else if (32'(channels_reg) > MAX_CHANNELS)
            eff_c = 3'(MAX_CHANNELS);
        else
            eff_c = channels_reg;
        eff_xs = (x_scale_reg == 16'd0) ? 16'd1 : x_scale_reg;
        eff_ys = (y_scale_reg == 16'd0) ? 16'd1 : y_scale_reg;
    end

    // sequencer registers
    logic [3:0]      state_reg, state_next;
    logic [15:0]     col_reg, col_next;
    logic [15:0]     row_reg, row_next;
    logic [1:0]      ch_reg, ch_next;
    logic [15:0]     oc_reg, oc_next;
    logic [15:0]     orr_reg, orr_next;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [15:0]     rem_reg, rem_next;
    logic [15:0]     dsr_reg, dsr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0]   px_reg, px_next;
    logic [XW-1:0]   x0_reg, x0_next, x1_reg, x1_next;
    logic [YW-1:0]   y0_reg, y0_next, y1_reg, y1_next;
    logic [FRAC_BITS-1:0] fh_reg, fh_next, fv_reg, fv_next;
    logic [1:0]      k_reg, k_next;
    logic [HW-1:0]   acch_reg, acch_next;
    logic [VW-1:0]   accv_reg, accv_next;
    logic            done_reg, done_next;
    logic [7:0]      pix_reg, pix_next;
    logic            err_reg, err_next;
    logic [15:0]     ocols_reg, ocols_next;
    logic [15:0]     orows_reg, orows_next;

    // frame store
    logic [7:0]    store [DEPTH];
    logic [7:0]    rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [XW-1:0] rd_x;
    logic [YW-1:0] rd_y;
    logic          corner_rep;

    assign wr_en = start && !busy && (cmd == bnis_pkg::CMD_LOAD)
                   && (32'(col) < 32'(eff_w)) && (32'(row) < 32'(eff_h))
                   && (3'(channel) < eff_c);
    assign wr_addr = AW'((32'(row) * MAX_WIDTH + 32'(col)) * MAX_CHANNELS
                         + 32'(channel));

    // the diagonal neighbour falls back to the top-left sample on either edge
    assign corner_rep = (k_reg == 2'd3) && ((x1_reg == x0_reg) || (y1_reg == y0_reg));
    assign rd_en   = (state_reg == S_RD);
    assign rd_x    = (k_reg[0] && !corner_rep) ? x1_reg : x0_reg;
    assign rd_y    = (k_reg[1] && !corner_rep) ? y1_reg : y0_reg;
    assign rd_addr = AW'((32'(rd_y) * MAX_WIDTH + 32'(rd_x)) * MAX_CHANNELS
                         + 32'(ch_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_addr] <= pixel_value;
        if (rd_en)
            rd_data_reg <= store[rd_addr];
    end

    // shared restoring divider step, one quotient bit per cycle
    logic [16:0] rem_sh;
    logic        div_ge;
    logic [16:0] rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[QW-1]};
    assign div_ge  = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    // output size products
    logic [DWW+15:0] wprod;
    logic [DHW+15:0] hprod;
    logic [15:0]     oc_calc, orr_calc;

    always_comb
    begin
        wprod = (DWW + 16)'(eff_w) * (DWW + 16)'(eff_xs);
        hprod = (DHW + 16)'(eff_h) * (DHW + 16)'(eff_ys);
        oc_calc  = ((wprod >> FRAC_BITS) > (DWW + 16)'(16'hFFFF)) ? 16'hFFFF
                 : 16'(wprod >> FRAC_BITS);
        orr_calc = ((hprod >> FRAC_BITS) > (DHW + 16)'(16'hFFFF)) ? 16'hFFFF
                 : 16'(hprod >> FRAC_BITS);
    end

    // source index from the positions
    logic [QW:0]   pxh, pyh;
    logic [IW-1:0] ix_raw, iy_raw;
    logic [XW-1:0] ix;
    logic [YW-1:0] iy;

    always_comb
    begin
        pxh = {1'b0, px_reg} + HALF;
        pyh = {1'b0, quo_reg} + HALF;
        if (interp_mode_reg == bnis_pkg::MODE_NEAREST)
        begin
            ix_raw = IW'(pxh >> FRAC_BITS);
            iy_raw = IW'(pyh >> FRAC_BITS);
        end
        else
        begin
            ix_raw = px_reg[QW-1:FRAC_BITS];
            iy_raw = quo_reg[QW-1:FRAC_BITS];
        end
        ix = (ix_raw >= IW'(eff_w)) ? XW'(eff_w - DWW'(1)) : ix_raw[XW-1:0];
        iy = (iy_raw >= IW'(eff_h)) ? YW'(eff_h - DHW'(1)) : iy_raw[YW-1:0];
    end

    // shared blend multiplier
    logic [HW-1:0]  mul_a;
    logic [WW-1:0]  mul_b;
    logic [MPW-1:0] mul_p;

    always_comb
    begin
        if (state_reg == S_MV)
        begin
            mul_a = acch_reg;
            mul_b = k_reg[1] ? WW'(fv_reg) : (ONE_W - WW'(fv_reg));
        end
        else
        begin
            mul_a = HW'(rd_data_reg);
            mul_b = k_reg[0] ? WW'(fh_reg) : (ONE_W - WW'(fh_reg));
        end
        mul_p = MPW'(mul_a) * MPW'(mul_b);
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        ch_next    = ch_reg;
        oc_next    = oc_reg;
        orr_next   = orr_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        cnt_next   = cnt_reg;
        px_next    = px_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        y0_next    = y0_reg;
        y1_next    = y1_reg;
        fh_next    = fh_reg;
        fv_next    = fv_reg;
        k_next     = k_reg;
        acch_next  = acch_reg;
        accv_next  = accv_reg;
        done_next  = 1'b0;
        pix_next   = pix_reg;
        err_next   = err_reg;
        ocols_next = ocols_reg;
        orows_next = orows_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && (cmd == bnis_pkg::CMD_REQUEST))
                begin
                    col_next   = col;
                    row_next   = row;
                    ch_next    = channel;
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                oc_next  = oc_calc;
                orr_next = orr_calc;
                if ((col_reg >= oc_calc) || (row_reg >= orr_calc)
                    || (3'(ch_reg) >= eff_c))
                begin
                    done_next  = 1'b1;
                    pix_next   = 8'd0;
                    err_next   = 1'b1;
                    ocols_next = oc_calc;
                    orows_next = orr_calc;
                    state_next = S_IDLE;
                end
                else
                begin
                    quo_next   = QW'(col_reg) << (2 * FRAC_BITS);
                    rem_next   = 16'd0;
                    dsr_next   = eff_xs;
                    cnt_next   = '0;
                    state_next = S_DIVX;
                end
            end
            S_DIVX, S_DIVY:
            begin
                rem_next = div_ge ? rem_sub[15:0] : rem_sh[15:0];
                quo_next = {quo_reg[QW-2:0], div_ge};
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(QW - 1))
                begin
                    if (state_reg == S_DIVX)
                    begin
                        px_next    = {quo_reg[QW-2:0], div_ge};
                        quo_next   = QW'(row_reg) << (2 * FRAC_BITS);
                        rem_next   = 16'd0;
                        dsr_next   = eff_ys;
                        cnt_next   = '0;
                        state_next = S_DIVY;
                    end
                    else
                        state_next = S_IDX;
                end
            end
            S_IDX:
            begin
                x0_next = ix;
                y0_next = iy;
                // past the right or bottom edge the top-left sample repeats
                x1_next = (32'(ix) >= 32'(eff_w) - 1) ? ix : ix + XW'(1);
                y1_next = (32'(iy) >= 32'(eff_h) - 1) ? iy : iy + YW'(1);
                fh_next = px_reg[FRAC_BITS-1:0];
                fv_next = quo_reg[FRAC_BITS-1:0];
                k_next  = 2'd0;
                state_next = S_RD;
            end
            S_RD:
                state_next = S_ACC;
            S_ACC:
            begin
                if (interp_mode_reg == bnis_pkg::MODE_NEAREST)
                begin
                    done_next  = 1'b1;
                    pix_next   = rd_data_reg;
                    err_next   = 1'b0;
                    ocols_next = oc_reg;
                    orows_next = orr_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    acch_next = (k_reg[0] ? acch_reg : HW'(0)) + HW'(mul_p);
                    if (k_reg[0])
                        state_next = S_MV;
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_RD;
                    end
                end
            end
            S_MV:
            begin
                accv_next = (k_reg[1] ? accv_reg : VW'(0)) + VW'(mul_p);
                if (k_reg == 2'd3)
                begin
                    done_next  = 1'b1;
                    pix_next   = 8'(accv_next >> (2 * FRAC_BITS));
                    err_next   = 1'b0;
                    ocols_next = oc_reg;
                    orows_next = orr_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            k_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        ch_reg    <= ch_next;
        oc_reg    <= oc_next;
        orr_reg   <= orr_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        px_reg    <= px_next;
        x0_reg    <= x0_next;
        x1_reg    <= x1_next;
        y0_reg    <= y0_next;
        y1_reg    <= y1_next;
        fh_reg    <= fh_next;
        fv_reg    <= fv_next;
        acch_reg  <= acch_next;
        accv_reg  <= accv_next;
        pix_reg   <= pix_next;
        err_reg   <= err_next;
        ocols_reg <= ocols_next;
        orows_reg <= orows_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign out_pixel   = pix_reg;
    assign coord_error = err_reg;
    assign out_cols    = ocols_reg;
    assign out_rows    = orows_reg;

    // a result always lands back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer still running");

    // a load never occupies the sequencer
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == bnis_pkg::CMD_LOAD)) |=> !busy && !done)
        else $error("load request started the sequencer");

    // a request always occupies the sequencer next cycle
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == bnis_pkg::CMD_REQUEST)) |=> busy)
        else $error("scaling request not taken");

    // an error result carries a zero sample
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && coord_error) |-> (out_pixel == 8'd0))
        else $error("out of range result with nonzero sample");

endmodule

`default_nettype wire

// ===== test/bilinear_nearest_image_scaler_core_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_nearest_image_scaler_core_test
// Drives loads and scaled-pixel requests through the command port under
// several register settings and with random start gaps. A mirror of the
// frame store and registers predicts every result. A scoreboard compares
// each result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bilinear_nearest_image_scaler_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ITEMS = 1850;
    localparam int STORE_DEPTH = bnis_pkg::DEF_MAX_WIDTH * bnis_pkg::DEF_MAX_HEIGHT
                                 * bnis_pkg::DEF_MAX_CHANNELS;

    typedef struct packed {
        logic [7:0]  pixel;
        logic        err;
        logic [15:0] cols;
        logic [15:0] rows;
    } scaled_px_t;

    class scaler_scoreboard;
        scaled_px_t pending[$];
        int n_checked;
        int n_errors;

        function void note_request(scaled_px_t e);
            pending.push_back(e);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            n_errors++;
        endtask

        task check_result(scaled_px_t got);
            scaled_px_t e;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (got.pixel !== e.pixel)
                report_mismatch($sformatf("out_pixel %h, want %h", got.pixel, e.pixel));
            if (got.err !== e.err)
                report_mismatch($sformatf("coord_error %b, want %b", got.err, e.err));
            if (got.cols !== e.cols)
                report_mismatch($sformatf("out_cols %h, want %h", got.cols, e.cols));
            if (got.rows !== e.rows)
                report_mismatch($sformatf("out_rows %h, want %h", got.rows, e.rows));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [bnis_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bnis_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic cmd = bnis_pkg::CMD_LOAD;
    logic [15:0] col = '0;
    logic [15:0] row = '0;
    logic [1:0] channel = '0;
    logic [7:0] pixel_value = '0;
    logic done;
    logic [7:0] out_pixel;
    logic coord_error;
    logic [15:0] out_cols;
    logic [15:0] out_rows;

    bilinear_nearest_image_scaler_core u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .cmd(cmd), .col(col), .row(row), .channel(channel), .pixel_value(pixel_value),
        .done(done), .out_pixel(out_pixel), .coord_error(coord_error),
        .out_cols(out_cols), .out_rows(out_rows)
    );

    scaler_scoreboard sb = new();

    // mirror of the frame store and of the registers
    logic [7:0] mirror_px[STORE_DEPTH];
    bit mirror_valid[STORE_DEPTH];
    logic [8:0] reg_width = bnis_pkg::RST_SRC_WIDTH;
    logic [8:0] reg_height = bnis_pkg::RST_SRC_HEIGHT;
    logic [2:0] reg_channels = bnis_pkg::RST_CHANNELS;
    logic [15:0] reg_xscale = bnis_pkg::RST_X_SCALE;
    logic [15:0] reg_yscale = bnis_pkg::RST_Y_SCALE;
    logic reg_mode = bnis_pkg::MODE_BILINEAR;

    bit calm;
    int n_items, n_loads, n_requests, n_flagged, n_phases;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{out_pixel, coord_error, out_cols, out_rows});
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
        if (v == 0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic int unsigned px_addr(int unsigned x, int unsigned y, int unsigned k);
        return ((y * bnis_pkg::DEF_MAX_WIDTH) + x) * bnis_pkg::DEF_MAX_CHANNELS + k;
    endfunction

    function automatic longint unsigned fetch(int unsigned x, int unsigned y,
                                              int unsigned k, inout bit ok);
        int unsigned a;
        a = px_addr(x, y, k);
        ok &= mirror_valid[a];
        return mirror_valid[a] ? mirror_px[a] : 0;
    endfunction

    function automatic longint unsigned scaled_size(int unsigned d, int unsigned s);
        longint unsigned v;
        v = (longint'(d) * s) >> bnis_pkg::DEF_FRAC_BITS;
        return (v > 65535) ? 65535 : v;
    endfunction

    // expected result of a request; returns 0 if it would read an unwritten sample
    function automatic bit predict_scaled(input logic [15:0] c, input logic [15:0] r,
                                          input logic [1:0] k, output scaled_px_t res);
        int unsigned w, h, nc, xs, ys, x, y;
        longint unsigned oc, orr, px, py, hw, vw, a0, a1, a2, a3, sum, one;
        bit ok, rx, by;
        ok = 1;
        w = clamp_dim(reg_width, bnis_pkg::DEF_MAX_WIDTH);
        h = clamp_dim(reg_height, bnis_pkg::DEF_MAX_HEIGHT);
        nc = clamp_dim(reg_channels, bnis_pkg::DEF_MAX_CHANNELS);
        xs = (reg_xscale == 0) ? 1 : reg_xscale;
        ys = (reg_yscale == 0) ? 1 : reg_yscale;
        oc = scaled_size(w, xs);
        orr = scaled_size(h, ys);
        res.cols = oc[15:0];
        res.rows = orr[15:0];
        res.pixel = '0;
        res.err = 1'b0;
        if (c >= oc || r >= orr || k >= nc)
        begin
            res.err = 1'b1;
            return 1;
        end
        px = (longint'(c) << (2 * bnis_pkg::DEF_FRAC_BITS)) / xs;
        py = (longint'(r) << (2 * bnis_pkg::DEF_FRAC_BITS)) / ys;
        if (reg_mode == bnis_pkg::MODE_NEAREST)
        begin
            px = (px + (1 << (bnis_pkg::DEF_FRAC_BITS - 1))) >> bnis_pkg::DEF_FRAC_BITS;
            py = (py + (1 << (bnis_pkg::DEF_FRAC_BITS - 1))) >> bnis_pkg::DEF_FRAC_BITS;
            x = (px >= w) ? w - 1 : 32'(px);
            y = (py >= h) ? h - 1 : 32'(py);
            res.pixel = 8'(fetch(x, y, k, ok));
        end
        else
        begin
            one = 1 << bnis_pkg::DEF_FRAC_BITS;
            hw = px & (one - 1);
            vw = py & (one - 1);
            x = ((px >> bnis_pkg::DEF_FRAC_BITS) >= w) ? w - 1
                : 32'(px >> bnis_pkg::DEF_FRAC_BITS);
            y = ((py >> bnis_pkg::DEF_FRAC_BITS) >= h) ? h - 1
                : 32'(py >> bnis_pkg::DEF_FRAC_BITS);
            rx = (x >= w - 1);
            by = (y >= h - 1);
            a0 = fetch(x, y, k, ok);
            a1 = rx ? a0 : fetch(x + 1, y, k, ok);
            a2 = by ? a0 : fetch(x, y + 1, k, ok);
            a3 = (rx || by) ? a0 : fetch(x + 1, y + 1, k, ok);
            sum = a0 * (one - hw) * (one - vw) + a1 * hw * (one - vw)
                + a2 * (one - hw) * vw + a3 * hw * vw;
            res.pixel = 8'(sum >> (2 * bnis_pkg::DEF_FRAC_BITS));
        end
        return ok;
    endfunction

    task send_item(logic c_cmd, logic [15:0] c_col, logic [15:0] c_row,
                   logic [1:0] c_ch, logic [7:0] c_val);
        scaled_px_t e;
        bit ok;
        if (!calm && $urandom_range(0, 99) < 13)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd <= c_cmd;
        col <= c_col;
        row <= c_row;
        channel <= c_ch;
        pixel_value <= c_val;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // request accepted at this edge
        if (c_cmd == bnis_pkg::CMD_LOAD)
        begin
            if (c_col < clamp_dim(reg_width, bnis_pkg::DEF_MAX_WIDTH) &&
                c_row < clamp_dim(reg_height, bnis_pkg::DEF_MAX_HEIGHT) &&
                c_ch < clamp_dim(reg_channels, bnis_pkg::DEF_MAX_CHANNELS))
            begin
                mirror_px[px_addr(c_col, c_row, c_ch)] = c_val;
                mirror_valid[px_addr(c_col, c_row, c_ch)] = 1;
                n_loads++;
                n_items++;
            end
        end
        else
        begin
            ok = predict_scaled(c_col, c_row, c_ch, e);
            sb.note_request(e);
            n_requests++;
            n_items++;
            if (e.err)
                n_flagged++;
        end
    endtask

    // asks for a pixel, redirecting to an out-of-range one if it would read an empty sample
    task ask_pixel(logic [15:0] c, logic [15:0] r, logic [1:0] k);
        scaled_px_t e;
        if (!predict_scaled(c, r, k, e))
            c = 16'hFFFF;
        send_item(bnis_pkg::CMD_REQUEST, c, r, k, 8'($urandom));
    endtask

    task settle;
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task program_regs(logic [15:0] w, logic [15:0] h, logic [15:0] nc,
                      logic [15:0] xs, logic [15:0] ys, logic [15:0] m);
        logic [15:0] vals[6];
        vals = '{w, h, nc, xs, ys, m};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= bnis_pkg::CFG_INDEX_W'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        reg_width = w[8:0];
        reg_height = h[8:0];
        reg_channels = nc[2:0];
        reg_xscale = xs;
        reg_yscale = ys;
        reg_mode = m[0];
        n_phases++;
    endtask

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'($urandom);
            4: return 16'd256;
            default: return 16'($urandom_range(100, 1200));
        endcase
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 11))
            0: return 16'd0;
            1: return 16'd511;
            2: return 16'd256;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    task random_phase;
        int unsigned w, h, nc, lw, lh, oc, orr, nreq;
        logic [15:0] c, r;
        logic [1:0] k;
        scaled_px_t e;
        bit ok;
        program_regs(pick_dim(), pick_dim(),
                     ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 7))
                                                  : 16'($urandom_range(1, 4)),
                     pick_scale(), pick_scale(), 16'($urandom_range(0, 1)));
        w = clamp_dim(reg_width, bnis_pkg::DEF_MAX_WIDTH);
        h = clamp_dim(reg_height, bnis_pkg::DEF_MAX_HEIGHT);
        nc = clamp_dim(reg_channels, bnis_pkg::DEF_MAX_CHANNELS);
        lw = (w > 6) ? 6 : w;
        lh = (h > 6) ? 6 : h;
        for (int y = 0; y < lh; y++)
            for (int x = 0; x < lw; x++)
                for (int ch = 0; ch < nc; ch++)
                    send_item(bnis_pkg::CMD_LOAD, 16'(x), 16'(y), 2'(ch), 8'($urandom));
        // the far corner too, so edge clamping is reachable on big images
        for (int ch = 0; ch < nc; ch++)
            send_item(bnis_pkg::CMD_LOAD, 16'(w - 1), 16'(h - 1), 2'(ch), 8'($urandom));
        ok = predict_scaled(0, 0, 0, e);
        oc = e.cols;
        orr = e.rows;
        nreq = $urandom_range(30, 70);
        for (int i = 0; i < nreq; i++)
        begin
            case ($urandom_range(0, 9))
                0: send_item(bnis_pkg::CMD_LOAD, 16'($urandom), 16'($urandom),
                             2'($urandom), 8'($urandom));
                1: ask_pixel(16'($urandom), 16'($urandom), 2'($urandom));
                default:
                begin
                    k = 2'($urandom_range(0, nc - 1));
                    c = (oc == 0) ? 16'd0 : 16'($urandom_range(0, oc - 1));
                    r = (orr == 0) ? 16'd0 : 16'($urandom_range(0, orr - 1));
                    for (int t = 0; t < 8 && !predict_scaled(c, r, k, e); t++)
                    begin
                        c = (oc == 0) ? 16'd0
                            : 16'($urandom_range(0, (oc > 12) ? 12 : oc - 1));
                        r = (orr == 0) ? 16'd0
                            : 16'($urandom_range(0, (orr > 12) ? 12 : orr - 1));
                    end
                    ask_pixel(c, r, k);
                end
            endcase
        end
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, corners and extremes, both modes
        send_item(bnis_pkg::CMD_LOAD, 0, 0, 0, 8'h00);
        send_item(bnis_pkg::CMD_LOAD, 1, 0, 0, 8'hFF);
        send_item(bnis_pkg::CMD_LOAD, 0, 1, 0, 8'hFF);
        send_item(bnis_pkg::CMD_LOAD, 1, 1, 0, 8'h5A);
        send_item(bnis_pkg::CMD_LOAD, 255, 255, 0, 8'hFF);
        send_item(bnis_pkg::CMD_LOAD, 255, 0, 0, 8'hA5);
        send_item(bnis_pkg::CMD_LOAD, 255, 1, 0, 8'h3C);
        send_item(bnis_pkg::CMD_LOAD, 0, 255, 0, 8'hC3);
        send_item(bnis_pkg::CMD_LOAD, 1, 255, 0, 8'h81);
        send_item(bnis_pkg::CMD_LOAD, 16'hFFFF, 0, 0, 8'h11);
        send_item(bnis_pkg::CMD_LOAD, 0, 16'hFFFF, 0, 8'h22);
        send_item(bnis_pkg::CMD_LOAD, 0, 0, 2'd3, 8'h33);
        for (int m = 0; m < 2; m++)
        begin
            ask_pixel(0, 0, 0);
            ask_pixel(255, 255, 0);
            ask_pixel(255, 0, 0);
            ask_pixel(0, 255, 0);
            ask_pixel(16'hFFFF, 0, 0);
            ask_pixel(0, 16'hFFFF, 0);
            ask_pixel(0, 0, 2'd3);
            settle();
            if (m == 0)
                program_regs(16'd256, 16'd256, 16'd1, 16'd256, 16'd256,
                             16'(bnis_pkg::MODE_NEAREST));
        end
        // an unknown register index must be harmless
        cfg_we <= 1'b1;
        cfg_index <= 3'd7;
        cfg_data <= 16'hFFFF;
        @(posedge clk);
        cfg_we <= 1'b0;
        ask_pixel(1, 1, 0);
        settle();

        while (n_items < NUM_ITEMS)
        begin
            calm = (n_phases % 9 == 4);
            random_phase();
        end
        calm = 0;

        settle();
        repeat (100) @(posedge clk);
        $display("covered %0d register settings, %0d stored samples, %0d pixel requests",
                 n_phases, n_loads, n_requests);
        $display("%0d requests flagged out of range, %0d results checked",
                 n_flagged, sb.n_checked);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
